>>> hw/rtl/chull_pkg.sv
// Package for the convex hull unit: shared constants, codes and state types.
// Depends on nothing; every other file of the block but chull_ram imports it.
`timescale 1ns / 1ps

package chull_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int COORD_BITS_DEF  = 16;
  localparam int TOL_BITS        = 20;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_ADDR_BITS   = 3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FEW  = 2'd1;
  localparam logic [1:0] STATUS_DROP = 2'd2;

  localparam logic REG_CROSS_TOL = 1'b0;
  localparam logic REG_DOT_TOL   = 1'b1;

  typedef enum logic {
    CMD_POINT,
    CMD_RUN
  } cmd_e;

  typedef enum logic [1:0] {
    PH_LOWER,
    PH_EXTRA,
    PH_UPPER
  } phase_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_FEW,
    S_KEY,
    S_KEYW,
    S_RD,
    S_CMP,
    H_PT,
    H_PTW,
    H_CHK,
    H_RPREV,
    H_RMID,
    H_DIFF,
    H_MUL,
    H_DEC,
    H_PUSH,
    E_RD
  } back_state_e;

endpackage

>>> hw/rtl/convex_hull_monotone_chain_unit.sv
// Top level of the convex hull unit: configuration registers on an APB-style
// port, front end queue and hull back end. Uses chull_pkg, chull_front, chull_back.
//
//   channel  | signals                              | direction
//   point    | point_valid_i / point_stall_o, x, y, final_point | in
//   hull     | hull_valid_o / hull_stall_i, x, y, last_vertex, status | out
//   config   | psel, penable, pwrite, paddr, pwdata, prdata, pready | in/out
//
// A point transaction is taken into a four-entry queue, and the back end stores
// each queued point. After the final point the in-place insertion sort shifts
// points one by one, the chains take each point in turn and each pop check uses
// the single shared multiplier. Vertices leave at one per cycle through the
// output register while the receiver does not stall; the first of a run and the
// first after a stall wait for a fresh stack read. Reset clears the queue, the
// point count and the registers; a stalled vertex is held.
`timescale 1ns / 1ps

module convex_hull_monotone_chain_unit
  import chull_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         point_valid_i,
  output logic                         point_stall_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic                         final_point_i,
  output logic                         hull_valid_o,
  input  logic                         hull_stall_i,
  output logic signed [COORD_BITS-1:0] hull_x_o,
  output logic signed [COORD_BITS-1:0] hull_y_o,
  output logic                         last_vertex_o,
  output logic [1:0]                   status_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_ADDR_BITS-1:0]     paddr,
  input  logic [CFG_DATA_BITS-1:0]     pwdata,
  output logic [CFG_DATA_BITS-1:0]     prdata,
  output logic                         pready
);

  logic [TOL_BITS-1:0]          cross_tol_q, dot_tol_q;
  logic                         q_valid, q_pop;
  cmd_e                         q_kind;
  logic signed [COORD_BITS-1:0] q_x, q_y;
  logic                         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign prdata  = (reg_sel == REG_DOT_TOL) ?
                   {{(CFG_DATA_BITS-TOL_BITS){1'b0}}, dot_tol_q} :
                   {{(CFG_DATA_BITS-TOL_BITS){1'b0}}, cross_tol_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cross_tol_q <= '0;
      dot_tol_q   <= '0;
    end else if (psel && penable && pwrite) begin
      if (reg_sel == REG_CROSS_TOL) begin
        cross_tol_q <= pwdata[TOL_BITS-1:0];
      end else begin
        dot_tol_q <= pwdata[TOL_BITS-1:0];
      end
    end
  end

  chull_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .point_valid_i (point_valid_i),
    .point_stall_o (point_stall_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .final_point_i (final_point_i),
    .q_valid_o     (q_valid),
    .q_pop_i       (q_pop),
    .q_kind_o      (q_kind),
    .q_x_o         (q_x),
    .q_y_o         (q_y)
  );

  chull_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_pop_o       (q_pop),
    .q_kind_i      (q_kind),
    .q_x_i         (q_x),
    .q_y_i         (q_y),
    .cross_tol_i   (cross_tol_q),
    .dot_tol_i     (dot_tol_q),
    .hull_valid_o  (hull_valid_o),
    .hull_stall_i  (hull_stall_i),
    .hull_x_o      (hull_x_o),
    .hull_y_o      (hull_y_o),
    .last_vertex_o (last_vertex_o),
    .status_o      (status_o)
  );

endmodule

>>> hw/rtl/chull_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module chull_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/chull_front.sv
// Front end of the hull unit: accepts points, tags them as plain points or as
// the final point, which starts a run, and holds them in a short queue. Uses chull_pkg.
`timescale 1ns / 1ps

module chull_front
  import chull_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         point_valid_i,
  output logic                         point_stall_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic                         final_point_i,
  output logic                         q_valid_o,
  input  logic                         q_pop_i,
  output cmd_e                         q_kind_o,
  output logic signed [COORD_BITS-1:0] q_x_o,
  output logic signed [COORD_BITS-1:0] q_y_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_e                         kind_q [QUEUE_DEPTH];
  logic signed [COORD_BITS-1:0] x_q    [QUEUE_DEPTH];
  logic signed [COORD_BITS-1:0] y_q    [QUEUE_DEPTH];
  logic [PW-1:0]                wp_q, rp_q;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic                         push, pop;

  assign point_stall_o = (cnt_q == CW'(QUEUE_DEPTH));
  assign push          = point_valid_i && !point_stall_o;
  assign pop           = q_pop_i && q_valid_o;
  assign q_valid_o     = (cnt_q != '0);
  assign q_kind_o      = kind_q[rp_q];
  assign q_x_o         = x_q[rp_q];
  assign q_y_o         = y_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wp_q <= wp_q + PW'(1);
      end
      if (pop) begin
        rp_q <= rp_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_q[wp_q] <= final_point_i ? CMD_RUN : CMD_POINT;
      x_q[wp_q]    <= point_x_i;
      y_q[wp_q]    <= point_y_i;
    end
  end

endmodule

>>> hw/rtl/chull_back.sv
// Back end of the hull unit: stores points, sorts them in place, builds the
// lower and upper chains on a stack and emits the hull. Uses chull_pkg, chull_ram.
`timescale 1ns / 1ps

module chull_back
  import chull_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  output logic                         q_pop_o,
  input  cmd_e                         q_kind_i,
  input  logic signed [COORD_BITS-1:0] q_x_i,
  input  logic signed [COORD_BITS-1:0] q_y_i,
  input  logic [TOL_BITS-1:0]          cross_tol_i,
  input  logic [TOL_BITS-1:0]          dot_tol_i,
  output logic                         hull_valid_o,
  input  logic                         hull_stall_i,
  output logic signed [COORD_BITS-1:0] hull_x_o,
  output logic signed [COORD_BITS-1:0] hull_y_o,
  output logic                         last_vertex_o,
  output logic [1:0]                   status_o
);

  localparam int SD  = MAX_POINTS + 1;
  localparam int PAW = $clog2(MAX_POINTS);
  localparam int SAW = $clog2(SD);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int TW  = $clog2(SD + 1);
  localparam int EW  = 2 * COORD_BITS;
  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int W   = (2 * COORD_BITS + 5 > TOL_BITS + 2) ? 2 * COORD_BITS + 5 : TOL_BITS + 2;

  back_state_e state_q, state_d;
  phase_e      phase_q, phase_d;

  logic [CW-1:0] cnt_q, cnt_d, n_q, n_d, i_q, i_d, j_q, j_d, rc_q, rc_d;
  logic          ovf_q, ovf_d;
  logic [1:0]    status_q, status_d;
  logic [TW-1:0] top_q, top_d, tgt_q, tgt_d, k_q, k_d;
  logic [2:0]    mstep_q, mstep_d;

  logic [EW-1:0] key_q, key_d, p_q, p_d, prev_q, prev_d;
  logic signed [DW-1:0] ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [W-1:0]  c_q, c_d, d_q, d_d;

  logic                         out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic signed [COORD_BITS-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [1:0]                   out_st_q, out_st_d;
  logic                         out_free;

  logic           p_we, s_we;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [EW-1:0]  p_wdata, p_rdata, s_rdata;

  logic [CW-1:0] cnt_ext, j_m1;
  logic [TW-1:0] top_m1, top_m2, top_new, floor_v;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [W-1:0]  prod_ext, csum, ctol, dtol;
  logic                 pop_now, gt, stored;

  chull_ram #(.WIDTH(EW), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  chull_ram #(.WIDTH(EW), .DEPTH(SD)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (p_q),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign out_free = !out_valid_q || !hull_stall_i;
  assign cnt_ext  = cnt_q;
  assign j_m1     = j_q - CW'(1);
  assign top_m1   = top_q - TW'(1);
  assign top_m2   = top_q - TW'(2);
  assign floor_v  = (phase_q == PH_LOWER) ? TW'(1) : tgt_q;

  // Sort order: x first, then y, both signed.
  assign gt = ($signed(p_rdata[EW-1:COORD_BITS]) > $signed(key_q[EW-1:COORD_BITS])) ||
              ((p_rdata[EW-1:COORD_BITS] == key_q[EW-1:COORD_BITS]) &&
               ($signed(p_rdata[COORD_BITS-1:0]) > $signed(key_q[COORD_BITS-1:0])));

  always_comb begin
    case (mstep_q)
      3'd0:    begin mul_a = ax_q; mul_b = by_q; end
      3'd1:    begin mul_a = ay_q; mul_b = bx_q; end
      3'd2:    begin mul_a = ax_q; mul_b = bx_q; end
      default: begin mul_a = ay_q; mul_b = by_q; end
    endcase
  end

  assign prod_ext = {{(W-PW){prod_q[PW-1]}}, prod_q};
  assign ctol     = {{(W-TOL_BITS){1'b0}}, cross_tol_i};
  assign dtol     = {{(W-TOL_BITS){1'b0}}, dot_tol_i};
  assign csum     = c_q + ctol;
  assign pop_now  = !c_q[W-1] || (!csum[W-1] && (csum != '0) && (d_q > dtol));

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    rc_d        = rc_q;
    status_d    = status_q;
    top_d       = top_q;
    tgt_d       = tgt_q;
    k_d         = k_q;
    mstep_d     = mstep_q;
    key_d       = key_q;
    p_d         = p_q;
    prev_d      = prev_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    bx_d        = bx_q;
    by_d        = by_q;
    prod_d      = prod_q;
    c_d         = c_q;
    d_d         = d_q;
    out_valid_d = out_valid_q && hull_stall_i;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_last_d  = out_last_q;
    out_st_d    = out_st_q;
    q_pop_o     = 1'b0;
    p_we        = 1'b0;
    p_waddr     = cnt_q[PAW-1:0];
    p_wdata     = {q_x_i, q_y_i};
    p_raddr     = rc_q[PAW-1:0];
    s_we        = 1'b0;
    s_waddr     = top_q[SAW-1:0];
    s_raddr     = top_m2[SAW-1:0];
    stored      = 1'b0;
    top_new     = top_q;

    unique case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (cnt_q < CW'(MAX_POINTS)) begin
            p_we   = 1'b1;
            stored = 1'b1;
            cnt_d  = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (q_kind_i == CMD_RUN) begin
            n_d      = stored ? cnt_ext + CW'(1) : cnt_ext;
            status_d = (ovf_q || !stored) ? STATUS_DROP : STATUS_OK;
            cnt_d    = '0;
            ovf_d    = 1'b0;
            i_d      = CW'(1);
            state_d  = (n_d < CW'(3)) ? B_FEW : S_KEY;
          end
        end
      end
      B_FEW: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_x_d     = '0;
          out_y_d     = '0;
          out_last_d  = 1'b1;
          out_st_d    = STATUS_FEW;
          state_d     = B_IDLE;
        end
      end
      S_KEY: begin
        p_raddr = i_q[PAW-1:0];
        if (i_q == n_q) begin
          phase_d = PH_LOWER;
          rc_d    = '0;
          top_d   = '0;
          state_d = H_PT;
        end else begin
          state_d = S_KEYW;
        end
      end
      S_KEYW: begin
        key_d   = p_rdata;
        j_d     = i_q;
        state_d = S_RD;
      end
      S_RD: begin
        p_raddr = j_m1[PAW-1:0];
        if (j_q == '0) begin
          p_we    = 1'b1;
          p_waddr = j_q[PAW-1:0];
          p_wdata = key_q;
          i_d     = i_q + CW'(1);
          state_d = S_KEY;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        p_we    = 1'b1;
        p_waddr = j_q[PAW-1:0];
        if (gt) begin
          p_wdata = p_rdata;
          j_d     = j_m1;
          state_d = S_RD;
        end else begin
          p_wdata = key_q;
          i_d     = i_q + CW'(1);
          state_d = S_KEY;
        end
      end
      H_PT: begin
        state_d = H_PTW;
      end
      H_PTW: begin
        p_d     = p_rdata;
        state_d = (phase_q == PH_EXTRA) ? H_PUSH : H_CHK;
      end
      H_CHK: begin
        if ((top_q >= TW'(2)) && (top_q > floor_v)) begin
          state_d = H_RPREV;
        end else begin
          state_d = H_PUSH;
        end
      end
      H_RPREV: begin
        s_raddr = top_m2[SAW-1:0];
        state_d = H_RMID;
      end
      H_RMID: begin
        prev_d  = s_rdata;
        s_raddr = top_m1[SAW-1:0];
        state_d = H_DIFF;
      end
      H_DIFF: begin
        ax_d    = DW'($signed(prev_q[EW-1:COORD_BITS])) - DW'($signed(s_rdata[EW-1:COORD_BITS]));
        ay_d    = DW'($signed(prev_q[COORD_BITS-1:0])) - DW'($signed(s_rdata[COORD_BITS-1:0]));
        bx_d    = DW'($signed(p_q[EW-1:COORD_BITS])) - DW'($signed(s_rdata[EW-1:COORD_BITS]));
        by_d    = DW'($signed(p_q[COORD_BITS-1:0])) - DW'($signed(s_rdata[COORD_BITS-1:0]));
        mstep_d = 3'd0;
        state_d = H_MUL;
      end
      H_MUL: begin
        // One multiplier: cross = ax*by - ay*bx, dot = ax*bx + ay*by.
        prod_d  = mul_a * mul_b;
        mstep_d = mstep_q + 3'd1;
        case (mstep_q)
          3'd1:    c_d = prod_ext;
          3'd2:    c_d = c_q - prod_ext;
          3'd3:    d_d = prod_ext;
          3'd4:    d_d = d_q + prod_ext;
          default: c_d = c_q;
        endcase
        if (mstep_q == 3'd4) begin
          state_d = H_DEC;
        end
      end
      H_DEC: begin
        if (pop_now) begin
          top_d   = top_m1;
          state_d = H_CHK;
        end else begin
          state_d = H_PUSH;
        end
      end
      H_PUSH: begin
        if (top_q < TW'(SD)) begin
          s_we    = 1'b1;
          top_new = top_q + TW'(1);
        end
        top_d   = top_new;
        state_d = H_PT;
        unique case (phase_q)
          PH_LOWER: begin
            if (rc_q == n_q - CW'(1)) begin
              phase_d = PH_EXTRA;
              rc_d    = n_q - CW'(2);
            end else begin
              rc_d = rc_q + CW'(1);
            end
          end
          PH_EXTRA: begin
            tgt_d   = top_new - TW'(1);
            phase_d = PH_UPPER;
            rc_d    = n_q - CW'(3);
          end
          default: begin
            if (rc_q == '0) begin
              // The leftmost point closes the chain and is not emitted twice.
              top_d   = top_new - TW'(1);
              k_d     = '0;
              state_d = (top_new == TW'(1)) ? B_IDLE : E_RD;
            end else begin
              rc_d = rc_q - CW'(1);
            end
          end
        endcase
      end
      E_RD: begin
        s_raddr = k_q[SAW-1:0];
        if (out_free) begin
          if (mstep_q == 3'd7) begin
            out_valid_d = 1'b1;
            out_x_d     = s_rdata[EW-1:COORD_BITS];
            out_y_d     = s_rdata[COORD_BITS-1:0];
            out_last_d  = (k_q == top_m1);
            out_st_d    = status_q;
            k_d         = k_q + TW'(1);
            mstep_d     = 3'd0;
            s_raddr     = k_d[SAW-1:0];
            if (k_q == top_m1) begin
              state_d = B_IDLE;
            end else begin
              mstep_d = 3'd7;
            end
          end else begin
            mstep_d = 3'd7;
          end
        end else begin
          mstep_d = 3'd0;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      phase_q     <= PH_LOWER;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      mstep_q     <= '0;
      top_q       <= '0;
      tgt_q       <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      mstep_q     <= mstep_d;
      top_q       <= top_d;
      tgt_q       <= tgt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    i_q        <= i_d;
    j_q        <= j_d;
    rc_q       <= rc_d;
    status_q   <= status_d;
    k_q        <= k_d;
    key_q      <= key_d;
    p_q        <= p_d;
    prev_q     <= prev_d;
    ax_q       <= ax_d;
    ay_q       <= ay_d;
    bx_q       <= bx_d;
    by_q       <= by_d;
    prod_q     <= prod_d;
    c_q        <= c_d;
    d_q        <= d_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_last_q <= out_last_d;
    out_st_q   <= out_st_d;
  end

  assign hull_valid_o  = out_valid_q;
  assign hull_x_o      = out_x_q;
  assign hull_y_o      = out_y_q;
  assign last_vertex_o = out_last_q;
  assign status_o      = out_st_q;

`ifndef SYNTHESIS
  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= TW'(SD))
    else $error("hull stack pointer beyond stack depth");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_upper_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_UPPER && state_q == H_CHK) |-> (top_q >= tgt_q))
    else $error("upper chain popped below the rightmost point");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && hull_stall_i) |=> (out_valid_q && $stable(out_x_q) && $stable(out_y_q)))
    else $error("stalled hull vertex overwritten");
`endif

endmodule

>>> dv/convex_hull_monotone_chain_unit_test.sv
// Self-checking testbench for the convex hull unit: point sets go in, and hull
// vertices are checked against a scoreboard that recomputes each hull.
// Depends on chull_pkg and convex_hull_monotone_chain_unit.
`timescale 1ns / 1ps

module convex_hull_monotone_chain_unit_test;
  import chull_pkg::*;

  localparam int CB         = COORD_BITS_DEF;
  localparam int CAP        = MAX_POINTS_DEF;
  localparam int CYCLE_CAP  = 1000000;
  localparam int DRAIN_WAIT = 60;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    coord_t     x;
    coord_t     y;
    logic       last;
    logic [1:0] status;
  } vertex_t;

  class hull_scoreboard;
    longint     set_x[CAP];
    longint     set_y[CAP];
    longint     chain_x[CAP+1];
    longint     chain_y[CAP+1];
    int         count;
    bit         dropped;
    longint     cross_tol;
    longint     dot_tol;
    vertex_t    vertex_q[$];
    int         errors;

    function void set_tolerance(bit is_dot, logic [31:0] value);
      if (is_dot) begin
        dot_tol = value[TOL_BITS-1:0];
      end else begin
        cross_tol = value[TOL_BITS-1:0];
      end
    endfunction

    function bit pops(int prev, int mid, int k);
      longint ax, ay, bx, by, c, d;
      ax = chain_x[prev] - chain_x[mid];
      ay = chain_y[prev] - chain_y[mid];
      bx = set_x[k] - chain_x[mid];
      by = set_y[k] - chain_y[mid];
      c  = ax * by - ay * bx;
      d  = ax * bx + ay * by;
      return (c >= 0) || (c > -cross_tol && d > dot_tol);
    endfunction

    function void push(ref int top, input int k);
      if (top < CAP + 1) begin
        chain_x[top] = set_x[k];
        chain_y[top] = set_y[k];
        top++;
      end
    endfunction

    function void note_point(coord_t x, coord_t y, logic fin);
      int n, top, tgt, emit, j;
      longint tx, ty;
      logic [1:0] st;
      vertex_t v;
      if (count < CAP) begin
        set_x[count] = x;
        set_y[count] = y;
        count++;
      end else begin
        dropped = 1'b1;
      end
      if (!fin) return;
      n  = count;
      st = dropped ? STATUS_DROP : STATUS_OK;
      count   = 0;
      dropped = 1'b0;
      if (n < 3) begin
        v = '{x: '0, y: '0, last: 1'b1, status: STATUS_FEW};
        vertex_q = {vertex_q, v};
        return;
      end
      for (int i = 1; i < n; i++) begin
        tx = set_x[i];
        ty = set_y[i];
        j  = i;
        while (j > 0 && (set_x[j-1] > tx || (set_x[j-1] == tx && set_y[j-1] > ty))) begin
          set_x[j] = set_x[j-1];
          set_y[j] = set_y[j-1];
          j--;
        end
        set_x[j] = tx;
        set_y[j] = ty;
      end
      top = 0;
      push(top, 0);
      push(top, 1);
      for (int rc = 2; rc < n; rc++) begin
        while (top >= 2 && pops(top - 2, top - 1, rc)) begin
          top--;
          if (top == 1) break;
        end
        push(top, rc);
      end
      push(top, n - 2);
      tgt = top - 1;
      for (int rc = n - 3; rc >= 0; rc--) begin
        while (top >= 2 && pops(top - 2, top - 1, rc)) begin
          top--;
          if (top == tgt) break;
        end
        push(top, rc);
      end
      top--;
      emit = (top < CAP) ? top : CAP;
      for (int k = 0; k < emit; k++) begin
        v.x      = coord_t'(chain_x[k]);
        v.y      = coord_t'(chain_y[k]);
        v.last   = (k == emit - 1);
        v.status = st;
        vertex_q = {vertex_q, v};
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t want;
      if (vertex_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected vertex x=%0d y=%0d last=%0b status=%0d",
                   got.x, got.y, got.last, got.status);
        return;
      end
      want = vertex_q[0];
      vertex_q.delete(0);
      if (got.x !== want.x || got.y !== want.y || got.last !== want.last ||
          got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("vertex mismatch: expected x=%0d y=%0d last=%0b status=%0d, got x=%0d y=%0d last=%0b status=%0d",
                   want.x, want.y, want.last, want.status,
                   got.x, got.y, got.last, got.status);
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     point_valid_i = 1'b0;
  logic                     point_stall_o;
  coord_t                   point_x_i = '0;
  coord_t                   point_y_i = '0;
  logic                     final_point_i = 1'b0;
  logic                     hull_valid_o;
  logic                     hull_stall_i = 1'b0;
  coord_t                   hull_x_o;
  coord_t                   hull_y_o;
  logic                     last_vertex_o;
  logic [1:0]               status_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  hull_scoreboard hull_sb = new();
  int             burst_left = 0;
  int             cycle_count = 0;
  int             stall_mode = 0;
  int             points_sent = 0;

  convex_hull_monotone_chain_unit uut (.*);

  always #2 clk_i = ~clk_i;

  // The receiver switches at random among four stall habits.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("[convex_hull_monotone_chain_unit] ERROR");
      $finish;
    end
    if (rst_ni && hull_valid_o && !hull_stall_i)
      hull_sb.check_vertex('{x: hull_x_o, y: hull_y_o, last: last_vertex_o,
                             status: status_o});
    if (cycle_count % 250 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: hull_stall_i <= 1'b0;
      1: hull_stall_i <= ($urandom_range(0, 9) < 3);
      2: hull_stall_i <= ($urandom_range(0, 9) < 7);
      default: hull_stall_i <= ((cycle_count / 7) % 3 == 0);
    endcase
  end

  task automatic send_point(coord_t x, coord_t y, logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        point_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    point_valid_i <= 1'b1;
    point_x_i     <= x;
    point_y_i     <= y;
    final_point_i <= fin;
    do @(posedge clk_i); while (point_stall_o);
    hull_sb.note_point(x, y, fin);
    points_sent++;
  endtask

  task automatic wait_drained();
    point_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (hull_sb.vertex_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic reg_idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CFG_ADDR_BITS'(reg_idx) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    hull_sb.set_tolerance(reg_idx == REG_DOT_TOL, value);
    @(posedge clk_i);
  endtask

  // Sizes are mostly small; now and then a set runs past capacity.
  task automatic random_set(int style);
    int n;
    coord_t x, y;
    n = ($urandom_range(0, 24) == 0) ? $urandom_range(CAP - 2, CAP + 4)
                                      : $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      case (style)
        0: begin
          x = coord_t'($urandom_range(0, 65535));
          y = coord_t'($urandom_range(0, 65535));
        end
        1: begin
          x = coord_t'(int'($urandom_range(0, 40)) - 20);
          y = coord_t'(int'($urandom_range(0, 40)) - 20);
        end
        default: begin
          x = coord_t'(int'($urandom_range(0, 60)) - 30);
          y = coord_t'(x * 2 + int'($urandom_range(0, 2)) - 1);
        end
      endcase
      send_point(x, y, i == n - 1);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(REG_CROSS_TOL, 32'd0);
    write_reg(REG_DOT_TOL, 32'd0);

    // A lone point and a pair are too few for a hull.
    send_point(16'sd5, -16'sd7, 1'b1);
    send_point(16'sd1, 16'sd1, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b1);
    // Square at the corners of the coordinate range with an interior point.
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(-16'sh8000, -16'sh8000, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sh7fff, -16'sh8000, 1'b0);
    send_point(-16'sh8000, 16'sh7fff, 1'b1);
    // Collinear and coincident sets collapse to two vertices.
    send_point(16'sd3, 16'sd3, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b1);
    send_point(-16'sd4, 16'sd9, 1'b0);
    send_point(-16'sd4, 16'sd9, 1'b0);
    send_point(-16'sd4, 16'sd9, 1'b1);
    // Equal x values exercise the tie break on y.
    send_point(16'sd0, 16'sd5, 1'b0);
    send_point(16'sd0, -16'sd5, 1'b0);
    send_point(16'sd4, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_CROSS_TOL, 32'hfff0_0000);
          write_reg(REG_DOT_TOL, 32'hffff_ffff);
        end
        1: begin
          write_reg(REG_CROSS_TOL, 32'h000f_ffff);
          write_reg(REG_DOT_TOL, 32'd0);
        end
        2: begin
          write_reg(REG_CROSS_TOL, $urandom_range(0, 200));
          write_reg(REG_DOT_TOL, $urandom_range(0, 200));
        end
        3: begin
          write_reg(REG_CROSS_TOL, $urandom());
          write_reg(REG_DOT_TOL, $urandom());
        end
        default: begin
          write_reg(REG_CROSS_TOL, 32'd0);
          write_reg(REG_DOT_TOL, 32'd0);
        end
      endcase
      while (points_sent < 18 + (phase + 1) * 86) begin
        random_set($urandom_range(0, 2));
        if ($urandom_range(0, 15) == 0) wait_drained();
      end
      wait_drained();
    end

    if (hull_sb.errors == 0) begin
      $display("[convex_hull_monotone_chain_unit] OK");
    end else begin
      $display("[convex_hull_monotone_chain_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> convex_hull_monotone_chain_unit.f
hw/rtl/chull_pkg.sv
hw/rtl/chull_ram.sv
hw/rtl/chull_front.sv
hw/rtl/chull_back.sv
hw/rtl/convex_hull_monotone_chain_unit.sv
dv/convex_hull_monotone_chain_unit_test.sv
